/* sv/bta_pkg.sv */
// shared constants for the three-input bfloat16 adder
package bta_pkg;

  localparam int unsigned BF_W     = 16;
  localparam int unsigned F32_W    = 32;
  localparam int unsigned BF_SHIFT = 16;
  localparam int unsigned ADD_LAT  = 3;
  localparam int unsigned TOT_LAT  = 2 * ADD_LAT + 1;

  localparam logic [F32_W-1:0] F32_DEF_NAN = 32'hFFC0_0000;
  localparam logic [F32_W-1:0] F32_QBIT    = 32'h0040_0000;
  localparam logic [BF_W-1:0]  BF_QBIT     = 16'h0040;
  localparam logic [BF_W-1:0]  BF_HALF     = 16'h7FFF;

endpackage

/* sv/bf16_three_input_adder.sv */
// top level: (a + b) + c on bfloat16 operands through an fp32 pipeline
//
// Usage:
//   A request is taken at each rising edge with start_i high and busy_o low.
//   busy_o is held low: the pipeline takes a new request every cycle.
//   The result appears on sum_value_o and last_out_o for exactly one cycle,
//   flagged by done_o, once the request has passed through the pipeline:
//   two three-stage fp32 adders in series (a + b, then + c) and one
//   narrowing stage back to bfloat16.
//   Throughput is one request per cycle; every stage carries its own valid
//   bit, so requests flow through without gaps.
//   Operand c travels beside the first adder in a delay line, and the last flag beside the whole pipeline.
//   The receiver cannot stall; results are never held back.
//   Reset (rst_ni low, asynchronous) clears all valid bits, so requests in
//   flight are dropped and no done_o is raised until a new request arrives.
module bf16_three_input_adder (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [bta_pkg::BF_W-1:0] a_value_i,
  input  logic [bta_pkg::BF_W-1:0] b_value_i,
  input  logic [bta_pkg::BF_W-1:0] c_value_i,
  input  logic                     last_in_i,
  output logic                     done_o,
  output logic [bta_pkg::BF_W-1:0] sum_value_o,
  output logic                     last_out_o
);
  import bta_pkg::*;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // first sum a + b
  logic             ab_vld;
  logic [F32_W-1:0] ab_res;

  bta_f32_add u_add_ab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .x_i    ({a_value_i, 16'd0}),
    .y_i    ({b_value_i, 16'd0}),
    .vld_o  (ab_vld),
    .res_o  (ab_res)
  );

  // delay lines for c and the last flag
  logic [BF_W-1:0] c_q [ADD_LAT];
  logic            last_q [TOT_LAT];

  always_ff @(posedge clk_i) begin
    c_q[0]    <= c_value_i;
    last_q[0] <= last_in_i;
    for (int i = 1; i < ADD_LAT; i++) begin
      c_q[i] <= c_q[i-1];
    end
    for (int i = 1; i < TOT_LAT; i++) begin
      last_q[i] <= last_q[i-1];
    end
  end

  // second sum (a + b) + c
  logic             abc_vld;
  logic [F32_W-1:0] abc_res;

  bta_f32_add u_add_c (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (ab_vld),
    .x_i    (ab_res),
    .y_i    ({c_q[ADD_LAT-1], 16'd0}),
    .vld_o  (abc_vld),
    .res_o  (abc_res)
  );

  // narrow back to bfloat16
  bta_narrow u_narrow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (abc_vld),
    .v_i    (abc_res),
    .vld_o  (done_o),
    .bf_o   (sum_value_o)
  );

  assign last_out_o = last_q[TOT_LAT-1];

endmodule

/* sv/bta_f32_add.sv */
// three-stage pipelined fp32 adder, round to nearest even, denormals kept
module bta_f32_add (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [bta_pkg::F32_W-1:0] x_i,
  input  logic [bta_pkg::F32_W-1:0] y_i,
  output logic                      vld_o,
  output logic [bta_pkg::F32_W-1:0] res_o
);
  import bta_pkg::*;

  function automatic logic [4:0] lzc27(input logic [26:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (m[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // stage 1: special operands, operand swap and alignment
  logic              x_nan, y_nan, x_inf, y_inf, swap;
  logic [31:0]       big, sml;
  logic [7:0]        eb, es, dexp;
  logic [26:0]       mb, ms, ms_sh, ms_mask;
  logic              spec_d;
  logic [31:0]       spec_val_d;
  logic [26:0]       ms_al_d;

  assign x_nan = (x_i[30:23] == 8'hFF) && (x_i[22:0] != '0);
  assign y_nan = (y_i[30:23] == 8'hFF) && (y_i[22:0] != '0);
  assign x_inf = (x_i[30:0] == 31'h7F80_0000);
  assign y_inf = (y_i[30:0] == 31'h7F80_0000);
  assign swap  = (x_i[30:0] < y_i[30:0]);
  assign big   = swap ? y_i : x_i;
  assign sml   = swap ? x_i : y_i;
  assign eb    = (big[30:23] == '0) ? 8'd1 : big[30:23];
  assign es    = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
  assign mb    = {big[30:23] != '0, big[22:0], 3'b000};
  assign ms    = {sml[30:23] != '0, sml[22:0], 3'b000};
  assign dexp  = eb - es;
  assign ms_sh   = ms >> dexp[4:0];
  assign ms_mask = ~(27'h7FF_FFFF << dexp[4:0]);

  always_comb begin
    spec_d     = 1'b1;
    spec_val_d = '0;
    if (x_nan) begin
      spec_val_d = x_i | F32_QBIT;
    end else if (y_nan) begin
      spec_val_d = y_i | F32_QBIT;
    end else if (x_inf) begin
      spec_val_d = (y_inf && (x_i[31] != y_i[31])) ? F32_DEF_NAN : x_i;
    end else if (y_inf) begin
      spec_val_d = y_i;
    end else begin
      spec_d = 1'b0;
    end
  end

  always_comb begin
    if (dexp >= 8'd27) begin
      ms_al_d = {26'd0, ms != '0};
    end else begin
      ms_al_d = ms_sh | {26'd0, (ms & ms_mask) != '0};
    end
  end

  logic        s1_vld_q;
  logic        s1_spec_q, s1_sign_q, s1_sub_q;
  logic [31:0] s1_spec_val_q;
  logic [7:0]  s1_e_q;
  logic [26:0] s1_mb_q, s1_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_spec_q     <= spec_d;
    s1_spec_val_q <= spec_val_d;
    s1_sign_q     <= big[31];
    s1_sub_q      <= x_i[31] ^ y_i[31];
    s1_e_q        <= eb;
    s1_mb_q       <= mb;
    s1_ms_q       <= ms_al_d;
  end

  // stage 2: add or subtract, leading-zero count
  logic [27:0] sum28;
  logic [26:0] diff, mant_d;
  logic [8:0]  e2_d;
  logic [4:0]  lz_d;
  logic        zero_d;

  assign sum28 = {1'b0, s1_mb_q} + {1'b0, s1_ms_q};
  assign diff  = s1_mb_q - s1_ms_q;

  always_comb begin
    mant_d = sum28[26:0];
    e2_d   = {1'b0, s1_e_q};
    lz_d   = '0;
    zero_d = 1'b0;
    if (s1_sub_q) begin
      mant_d = diff;
      zero_d = (diff == '0);
      lz_d   = lzc27(diff);
    end else if (sum28[27]) begin
      mant_d = sum28[27:1] | {26'd0, sum28[0]};
      e2_d   = {1'b0, s1_e_q} + 9'd1;
    end
  end

  logic        s2_vld_q;
  logic        s2_spec_q, s2_sign_q, s2_zero_q;
  logic [31:0] s2_spec_val_q;
  logic [26:0] s2_mant_q;
  logic [8:0]  s2_e_q;
  logic [4:0]  s2_lz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_spec_q     <= s1_spec_q;
    s2_spec_val_q <= s1_spec_val_q;
    s2_sign_q     <= s1_sign_q;
    s2_zero_q     <= zero_d;
    s2_mant_q     <= mant_d;
    s2_e_q        <= e2_d;
    s2_lz_q       <= lz_d;
  end

  // stage 3: normalise, round and pack
  logic [8:0]  emax, en, er;
  logic [4:0]  sh;
  logic [26:0] mn;
  logic        inc;
  logic [24:0] mr;
  logic [23:0] mf;
  logic [31:0] res_d;

  assign emax = s2_e_q - 9'd1;
  assign sh   = ({4'd0, s2_lz_q} > emax) ? emax[4:0] : s2_lz_q;
  assign mn   = s2_mant_q << sh;
  assign en   = s2_e_q - {4'd0, sh};
  assign inc  = mn[2] & (mn[1] | mn[0] | mn[3]);
  assign mr   = {1'b0, mn[26:3]} + {24'd0, inc};
  assign mf   = mr[24] ? mr[24:1] : mr[23:0];
  assign er   = mr[24] ? en + 9'd1 : en;

  always_comb begin
    if (s2_spec_q) begin
      res_d = s2_spec_val_q;
    end else if (s2_zero_q) begin
      res_d = '0;
    end else if (er >= 9'd255) begin
      res_d = {s2_sign_q, 8'hFF, 23'd0};
    end else begin
      res_d = {s2_sign_q, mf[23] ? er[7:0] : 8'd0, mf[22:0]};
    end
  end

  logic        s3_vld_q;
  logic [31:0] s3_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_res_q <= res_d;
  end

  assign vld_o = s3_vld_q;
  assign res_o = s3_res_q;

  // checks
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> ##3 vld_o) else $error("adder valid lost");
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && (x_nan || y_nan)) |-> ##3 (res_o[30:23] == 8'hFF && res_o[22]))
    else $error("nan not propagated");
  a_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && x_inf && y_inf && (x_i[31] != y_i[31])) |-> ##3 (res_o == F32_DEF_NAN))
    else $error("inf minus inf not default nan");

endmodule

/* sv/bta_narrow.sv */
// fp32 to bfloat16 narrowing stage, nearest even, denormals flushed
module bta_narrow (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [bta_pkg::F32_W-1:0] v_i,
  output logic                      vld_o,
  output logic [bta_pkg::BF_W-1:0]  bf_o
);
  import bta_pkg::*;

  logic              is_nan;
  logic [F32_W-1:0]  rnd;
  logic [BF_W-1:0]   bf_d;

  assign is_nan = (v_i[30:23] == 8'hFF) && (v_i[22:0] != '0);
  assign rnd    = v_i + {16'd0, BF_HALF} + {31'd0, v_i[BF_SHIFT]};

  // pick quieted nan, signed zero or rounded value
  always_comb begin
    if (is_nan) begin
      bf_d = v_i[F32_W-1:BF_SHIFT] | BF_QBIT;
    end else if (v_i[30:23] == '0) begin
      bf_d = {v_i[31], 15'd0};
    end else begin
      bf_d = rnd[F32_W-1:BF_SHIFT];
    end
  end

  logic            vld_q;
  logic [BF_W-1:0] bf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bf_q <= bf_d;
  end

  assign vld_o = vld_q;
  assign bf_o  = bf_q;

endmodule
